// ===== rtl/matc_pkg.sv =====
// Shared types and constants for the multi-alarm time comparator.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package matc_pkg;

    localparam int NUM_ALARMS = 5;
    localparam int IDX_W      = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;
    localparam int SLOT_W     = 3;
    localparam int FIELD_W    = 8;
    localparam int NUM_FIELDS = 6;
    localparam int TIME_W     = FIELD_W * NUM_FIELDS;
    localparam int MASK_W     = NUM_FIELDS;
    localparam logic [MASK_W-1:0] MASK_RESET = '1;

    localparam int S_TDATA_W = ((SLOT_W + TIME_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((SLOT_W + 7) / 8) * 8;
    localparam int KIND_W    = 2;

    localparam logic OP_SET   = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    typedef enum logic [1:0] {
        ST_NEVER = 2'd0,
        ST_ARMED = 2'd1,
        ST_FIRED = 2'd2
    } slot_status_t;

    typedef enum logic [KIND_W-1:0] {
        EV_ACCEPT = 2'd0,
        EV_ARMED  = 2'd1,
        EV_BADIDX = 2'd2,
        EV_HIT    = 2'd3
    } event_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SET,
        S_SCAN,
        S_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic load_item;
        logic do_set;
        logic scan_step;
        logic emit_step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic hits_any;
        logic out_free;
        logic emit_last;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/matc_ctrl.sv =====
// Controller state machine of the alarm comparator: sequences set, scan and emit.
// Depends on matc_pkg; drives the datapath through ctrl_cmd_t.
`default_nettype none

module matc_ctrl (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_tvalid,
    input  wire                  s_tuser,
    output logic                 s_tready,
    input  matc_pkg::dp_status_t status,
    output matc_pkg::ctrl_cmd_t  cmd
);
    import matc_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next    = (s_tuser == OP_CHECK) ? S_SCAN : S_SET;
                end
            end
            S_SET: begin
                if (status.out_free) begin
                    cmd.do_set = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (status.scan_last) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!status.hits_any) begin
                    state_next = S_IDLE;
                end else if (status.out_free) begin
                    cmd.emit_step = 1'b1;
                    if (status.emit_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/matc_dp.sv =====
// Datapath of the alarm comparator: slot store, match logic, hit list and output register.
// Depends on matc_pkg; commanded by matc_ctrl.
`default_nettype none

module matc_dp (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                cfg_wr_en,
    input  wire  [matc_pkg::MASK_W-1:0]        cfg_wr_data,
    input  wire  [matc_pkg::S_TDATA_W-1:0]     s_tdata,
    input  matc_pkg::ctrl_cmd_t                cmd,
    output matc_pkg::dp_status_t               status,
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [matc_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic [matc_pkg::KIND_W-1:0]        m_tuser,
    output logic                               m_tlast
);
    import matc_pkg::*;

    logic [MASK_W-1:0]      match_mask_reg;
    logic [SLOT_W-1:0]      idx_reg;
    logic [TIME_W-1:0]      time_reg;
    logic [TIME_W-1:0]      times_reg [NUM_ALARMS];
    slot_status_t           status_reg [NUM_ALARMS];
    logic [IDX_W-1:0]       cnt_reg;
    logic [NUM_ALARMS-1:0]  hit_reg;
    logic [NUM_ALARMS-1:0]  hit_next;

    logic                   m_valid_reg;
    event_t                 m_kind_reg;
    logic [SLOT_W-1:0]      m_slot_reg;
    logic                   m_last_reg;

    logic                   idx_ok;
    logic [IDX_W-1:0]       set_sel;
    event_t                 set_kind;
    logic [TIME_W-1:0]      cur_time;
    logic [MASK_W-1:0]      flags;
    logic                   slot_hit;
    logic [IDX_W-1:0]       first_hit;
    logic                   out_free;

    assign idx_ok  = (int'(idx_reg) < NUM_ALARMS);
    assign set_sel = idx_reg[IDX_W-1:0];

    always_comb begin
        if (!idx_ok) begin
            set_kind = EV_BADIDX;
        end else if (status_reg[set_sel] == ST_ARMED) begin
            set_kind = EV_ARMED;
        end else begin
            set_kind = EV_ACCEPT;
        end
    end

    // seconds match once the alarm second has been reached; other fields on equality
    assign cur_time = times_reg[cnt_reg];
    always_comb begin
        flags[0] = (cur_time[FIELD_W-1:0] <= time_reg[FIELD_W-1:0]);
        for (int f = 1; f < NUM_FIELDS; f++) begin
            flags[f] = (cur_time[f*FIELD_W +: FIELD_W] == time_reg[f*FIELD_W +: FIELD_W]);
        end
    end
    assign slot_hit = (status_reg[cnt_reg] == ST_ARMED)
                   && ((flags & match_mask_reg) == match_mask_reg);

    always_comb begin
        first_hit = '0;
        for (int i = NUM_ALARMS - 1; i >= 0; i--) begin
            if (hit_reg[i]) begin
                first_hit = IDX_W'(i);
            end
        end
    end

    always_comb begin
        hit_next = hit_reg;
        if (cmd.load_item) begin
            hit_next = '0;
        end else if (cmd.scan_step && slot_hit) begin
            hit_next[cnt_reg] = 1'b1;
        end else if (cmd.emit_step) begin
            hit_next[first_hit] = 1'b0;
        end
    end

    assign out_free = !m_valid_reg || m_tready;

    assign status.scan_last = (cnt_reg == IDX_W'(NUM_ALARMS - 1));
    assign status.hits_any  = |hit_reg;
    assign status.out_free  = out_free;
    assign status.emit_last = ((hit_reg & (hit_reg - 1'b1)) == '0);

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_mask_reg <= MASK_RESET;
            cnt_reg        <= '0;
            hit_reg        <= '0;
            m_valid_reg    <= 1'b0;
            for (int i = 0; i < NUM_ALARMS; i++) begin
                status_reg[i] <= ST_NEVER;
            end
        end else begin
            if (cfg_wr_en) begin
                match_mask_reg <= cfg_wr_data;
            end
            hit_reg <= hit_next;
            if (cmd.load_item) begin
                cnt_reg <= '0;
            end else if (cmd.scan_step) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.do_set && set_kind == EV_ACCEPT) begin
                status_reg[set_sel] <= ST_ARMED;
            end else if (cmd.scan_step && slot_hit) begin
                status_reg[cnt_reg] <= ST_FIRED;
            end
            if (cmd.do_set || cmd.emit_step) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            idx_reg  <= s_tdata[SLOT_W-1:0];
            time_reg <= s_tdata[SLOT_W +: TIME_W];
        end
        if (cmd.do_set && set_kind == EV_ACCEPT) begin
            times_reg[set_sel] <= time_reg;
        end else if (cmd.scan_step && slot_hit) begin
            times_reg[cnt_reg] <= '0;
        end
        if (cmd.do_set) begin
            m_kind_reg <= set_kind;
            m_slot_reg <= idx_reg;
            m_last_reg <= 1'b1;
        end else if (cmd.emit_step) begin
            m_kind_reg <= EV_HIT;
            m_slot_reg <= SLOT_W'(first_hit);
            m_last_reg <= status.emit_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(m_slot_reg);
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

// ===== rtl/multi_alarm_time_comparator_top.sv =====
// Top level of the multi-alarm time comparator.
// Depends on matc_pkg, matc_ctrl and matc_dp.
`default_nettype none

// Holds NUM_ALARMS alarm slots (six time bytes and a never set / armed / fired
// status each). A set item is loaded into the item registers and yields its single
// status result once the output register is free. A time check walks the slots one
// per cycle through a single compare unit, then hands out one hit per cycle from the
// hit list while the result side does not stall. A check that hits nothing gives no
// result. Items are taken one at a time; match_mask is written through cfg_wr_en /
// cfg_wr_data and resets to all ones. The user must write it only while the block
// is idle; the block itself does not enforce this.
module multi_alarm_time_comparator_top (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                cfg_wr_en,
    input  wire  [matc_pkg::MASK_W-1:0]        cfg_wr_data,   // match_mask
    input  wire                                s_tvalid,
    output logic                               s_tready,
    // slot_index[2:0], second_val, minute_val, hour_val, day_val, month_val,
    // year_val (8 bits each, from bit 3 up), zero pad
    input  wire  [matc_pkg::S_TDATA_W-1:0]     s_tdata,
    input  wire                                s_tuser,       // opcode
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [matc_pkg::M_TDATA_W-1:0]     m_tdata,       // slot_number[2:0], zero pad
    output logic [matc_pkg::KIND_W-1:0]        m_tuser,       // event_kind
    output logic                               m_tlast        // last_of_run
);
    import matc_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    matc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    matc_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .cmd         (cmd),
        .status      (status),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

`default_nettype wire

// ===== bench/alarm_event_checker.sv =====
// Checker for the multi-alarm time comparator: watches both stream channels and the
// match_mask write port, predicts the alarm events and compares them as they come out.
// Depends on matc_pkg.

module alarm_event_checker (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              cfg_wr_en,
    input  wire  [matc_pkg::MASK_W-1:0]      cfg_wr_data,
    input  wire                              s_tvalid,
    input  wire                              s_tready,
    input  wire  [matc_pkg::S_TDATA_W-1:0]   s_tdata,     // slot_index[2:0], sec..year bytes, zero pad
    input  wire                              s_tuser,     // opcode
    input  wire                              m_tvalid,
    input  wire                              m_tready,
    input  wire  [matc_pkg::M_TDATA_W-1:0]   m_tdata,     // slot_number[2:0], zero pad
    input  wire  [matc_pkg::KIND_W-1:0]      m_tuser,     // event_kind
    input  wire                              m_tlast,     // last_of_run
    output int                               fail_count,
    output int                               pending
);
    import matc_pkg::*;

    typedef struct packed {
        event_t             kind;
        logic [SLOT_W-1:0]  slot;
        logic               last;
    } alarm_event_t;

    logic [TIME_W-1:0] alarm_time [NUM_ALARMS];
    slot_status_t      alarm_state [NUM_ALARMS];
    logic [MASK_W-1:0] field_mask;
    alarm_event_t      awaited_events [$];
    int                errors = 0;

    // seconds fire once the current second has reached the stored one; the rest on equality
    function automatic logic [MASK_W-1:0] field_matches(input logic [TIME_W-1:0] alarm,
                                                        input logic [TIME_W-1:0] now);
        logic [MASK_W-1:0] m;
        int f;
        m[0] = (alarm[FIELD_W-1:0] <= now[FIELD_W-1:0]);
        for (f = 1; f < NUM_FIELDS; f++)
            m[f] = (alarm[f*FIELD_W +: FIELD_W] == now[f*FIELD_W +: FIELD_W]);
        return m;
    endfunction

    task automatic predict_alarm_events(input logic op, input logic [SLOT_W-1:0] idx,
                                        input logic [TIME_W-1:0] now);
        alarm_event_t ev;
        int hit_slots [$];
        int i;
        if (op == OP_SET) begin
            ev.slot = idx;
            ev.last = 1'b1;
            if (idx >= NUM_ALARMS) begin
                ev.kind = EV_BADIDX;
            end else if (alarm_state[idx] == ST_ARMED) begin
                ev.kind = EV_ARMED;
            end else begin
                alarm_time[idx]  = now;
                alarm_state[idx] = ST_ARMED;
                ev.kind = EV_ACCEPT;
            end
            awaited_events.push_back(ev);
        end else begin
            for (i = 0; i < NUM_ALARMS; i++) begin
                if (alarm_state[i] == ST_ARMED &&
                    (field_matches(alarm_time[i], now) & field_mask) == field_mask) begin
                    alarm_time[i]  = '0;
                    alarm_state[i] = ST_FIRED;
                    hit_slots.push_back(i);
                end
            end
            for (i = 0; i < hit_slots.size(); i++) begin
                ev.kind = EV_HIT;
                ev.slot = SLOT_W'(hit_slots[i]);
                ev.last = (i == hit_slots.size() - 1);
                awaited_events.push_back(ev);
            end
        end
    endtask

    task automatic check_alarm_event();
        alarm_event_t want;
        if (awaited_events.size() == 0) begin
            $error("unexpected item: event_kind %0d slot_number %0d last_of_run %0b",
                   m_tuser, m_tdata[SLOT_W-1:0], m_tlast);
            errors++;
        end else begin
            want = awaited_events.pop_front();
            if (m_tuser !== want.kind) begin
                $error("event_kind: expected %0d, got %0d", want.kind, m_tuser);
                errors++;
            end
            if (m_tdata[SLOT_W-1:0] !== want.slot) begin
                $error("slot_number: expected %0d, got %0d", want.slot, m_tdata[SLOT_W-1:0]);
                errors++;
            end
            if (m_tlast !== want.last) begin
                $error("last_of_run: expected %0b, got %0b", want.last, m_tlast);
                errors++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_ALARMS; i++) begin
                alarm_time[i]  = '0;
                alarm_state[i] = ST_NEVER;
            end
            field_mask = MASK_RESET;
            awaited_events.delete();
        end else begin
            if (cfg_wr_en)
                field_mask = cfg_wr_data;
            // an item's results are registered after its set or scan state, so this order is safe
            if (s_tvalid && s_tready)
                predict_alarm_events(s_tuser, s_tdata[SLOT_W-1:0], s_tdata[SLOT_W +: TIME_W]);
            if (m_tvalid && m_tready)
                check_alarm_event();
        end
        pending    <= awaited_events.size();
        fail_count <= errors;
    end

endmodule

// ===== bench/testbench.sv =====
// Top of the multi-alarm time comparator bench: clock, reset, stimulus and verdict.
// Depends on matc_pkg, multi_alarm_time_comparator_top and alarm_event_checker.

module testbench;
    import matc_pkg::*;

    localparam int LIMIT = 5_000_000;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [MASK_W-1:0]     cfg_wr_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [KIND_W-1:0]     m_tuser;
    logic                  m_tlast;
    int                    fail_count;
    int                    pending;

    bit                    burst_mode;
    bit                    hold_off_req;
    logic [TIME_W-1:0]     last_set_time [8];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    multi_alarm_time_comparator_top DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    alarm_event_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    // mostly short gaps, now and then a long one; none at all in burst mode
    function automatic int idle_gap();
        int r;
        if (burst_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [TIME_W-1:0] pack_time(input int sec, input int min,
                                                    input int hour, input int day,
                                                    input int month, input int year);
        return {8'(year), 8'(month), 8'(day), 8'(hour), 8'(min), 8'(sec)};
    endfunction

    function automatic logic [TIME_W-1:0] random_time();
        return TIME_W'({$urandom(), $urandom()});
    endfunction

    task automatic offer_item(input logic op, input logic [SLOT_W-1:0] idx,
                              input logic [TIME_W-1:0] tm);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        if (op == OP_SET)
            last_set_time[idx] = tm;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= S_TDATA_W'({tm, idx});
        do @(posedge aclk); while (!s_tready);
    endtask

    // block idle: every awaited event seen, then room for a check that hits nothing
    task automatic settle();
        s_tvalid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic write_mask(input logic [MASK_W-1:0] mask);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mask;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // sets over random slots, checks mostly aimed near a time recently set
    task automatic random_item();
        int r;
        int b;
        logic [TIME_W-1:0] tm;
        logic [SLOT_W-1:0] idx;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            if ($urandom_range(0, 9) == 0)
                idx = SLOT_W'($urandom_range(NUM_ALARMS, 7));
            else
                idx = SLOT_W'($urandom_range(0, NUM_ALARMS - 1));
            offer_item(OP_SET, idx, random_time());
        end else if (r < 85) begin
            tm = last_set_time[$urandom_range(0, 7)];
            // one second early up to three late
            tm[7:0] = tm[7:0] + 8'($urandom_range(0, 4)) - 8'd1;
            if ($urandom_range(0, 4) == 0) begin
                b = $urandom_range(FIELD_W, TIME_W - 1);
                tm[b] = ~tm[b];
            end
            offer_item(OP_CHECK, SLOT_W'($urandom), tm);
        end else begin
            offer_item(OP_CHECK, SLOT_W'($urandom), random_time());
        end
    endtask

    initial begin
        int stall;
        m_tready = 1'b0;
        wait (aresetn);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
            end else begin
                stall = idle_gap();
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
    end

    initial begin
        int phase;
        int n;
        logic [MASK_W-1:0] mask;
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = OP_SET;
        burst_mode   = 1'b0;
        hold_off_req = 1'b0;
        foreach (last_set_time[i])
            last_set_time[i] = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_mask(6'b111111);

        // directed: full mask
        offer_item(OP_CHECK, 3'd7, '0);                          // nothing armed
        offer_item(OP_SET, 3'd0, '1);
        offer_item(OP_SET, 3'd0, random_time());                 // already armed
        offer_item(OP_SET, 3'd5, random_time());                 // bad indexes
        offer_item(OP_SET, 3'd6, random_time());
        offer_item(OP_SET, 3'd7, '1);
        offer_item(OP_SET, 3'd1, '0);
        offer_item(OP_SET, 3'd4, pack_time(30, 15, 12, 1, 6, 24));
        offer_item(OP_CHECK, 3'd0, pack_time(29, 15, 12, 1, 6, 24));  // second too early
        offer_item(OP_CHECK, 3'd5, pack_time(31, 15, 12, 1, 6, 24));
        offer_item(OP_CHECK, 3'd2, '0);
        offer_item(OP_CHECK, 3'd1, '1);
        offer_item(OP_SET, 3'd4, pack_time(59, 59, 23, 31, 12, 99));  // re-arm after firing
        offer_item(OP_SET, 3'd2, '0);
        offer_item(OP_SET, 3'd3, pack_time(0, 255, 0, 255, 0, 255));
        offer_item(OP_CHECK, 3'd3, pack_time(59, 59, 23, 31, 12, 98)); // year differs

        // directed: empty mask, every armed slot fires
        settle();
        write_mask(6'b000000);
        offer_item(OP_CHECK, 3'd6, random_time());
        for (n = 0; n < NUM_ALARMS; n++)
            offer_item(OP_SET, SLOT_W'(n), random_time());
        offer_item(OP_CHECK, 3'd0, random_time());

        for (phase = 0; phase < 7; phase++) begin
            settle();
            case (phase)
                0:       mask = 6'b111111;
                1:       mask = 6'b000001;
                2:       mask = 6'b000000;
                4:       mask = 6'b111110;
                5:       mask = 6'b111111;
                default: mask = MASK_W'($urandom);
            endcase
            write_mask(mask);
            burst_mode = (phase == 4);
            for (n = 0; n < 40; n++) begin
                if (phase == 1 && n == 15)
                    hold_off_req = 1'b1;
                random_item();
            end
        end
        burst_mode = 1'b0;
        settle();

        if (fail_count == 0)
            $display("** multi_alarm_time_comparator_top: PASSED **");
        else
            $display("** multi_alarm_time_comparator_top: FAILED **");
        $finish;
    end

    initial begin
        #(LIMIT);
        $display("** multi_alarm_time_comparator_top: FAILED **");
        $finish;
    end

endmodule

// ===== multi_alarm_time_comparator_top.f =====
rtl/matc_pkg.sv
rtl/matc_ctrl.sv
rtl/matc_dp.sv
rtl/multi_alarm_time_comparator_top.sv
bench/alarm_event_checker.sv
bench/testbench.sv
